// ----- design/crs_pkg.sv -----
package crs_pkg;

  // Magic word that opens a record ('PSYS', little-endian)
  localparam logic [31:0] ScanMagic = 32'h5359_5350;
  // Reflected CRC-32 polynomial
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  // Byte position saturates here
  localparam logic [17:0] PosCeiling = 18'h2_0000;
  // Reset value of the area length register
  localparam logic [16:0] AreaReset = 17'd4096;

  // Scanner phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_CRC   = 5'b00010,
    PH_FLAGS = 5'b00100,
    PH_LENS  = 5'b01000,
    PH_BODY  = 5'b10000
  } phase_e;

  // Report codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CRC_FAIL = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_AREA_END = 3'd4
  } status_e;

  // One input word of the area
  typedef struct packed {
    logic        last_word;
    logic [31:0] data_word;
  } item_t;

  // One report
  typedef struct packed {
    status_e     status;
    logic [15:0] record_offset;
    logic [31:0] record_flags;
    logic [15:0] name_length;
    logic [15:0] value_length;
    logic        area_done;
  } result_t;

  // Column i: CRC register after 32 shifts, starting from bit i alone
  typedef logic [31:0][31:0] crc_cols_t;

  function automatic crc_cols_t crc_columns();
    crc_cols_t   cols;
    logic [31:0] v;
    for (int i = 0; i < 32; i++) begin
      v = 32'd1 << i;
      for (int k = 0; k < 32; k++) begin
        v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
      end
      cols[i] = v;
    end
    return cols;
  endfunction

  localparam crc_cols_t CrcCols = crc_columns();

endpackage

// ----- design/crc_checked_record_scanner_top.sv -----
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: data_word; tlast: last_word
// m_axis    out  m_axis_tvalid/tready        tdata: offset, flags, lengths; tuser: status;
//                                            tlast: area_done
// cfg       in   cfg_we_i                    cfg_wdata_i: area_bytes
//
// One word is taken per cycle unless a stalled result holds the core; a word passes an input
// register, then the scan logic with one 32-bit CRC fold writes the result register,
// which drives m_axis.
// Reset clears the scan state and sets the area length to 4096 bytes.
// A stalled result holds in the result register while one more word can be taken;
// after that s_axis_tready follows m_axis_tready.
module crc_checked_record_scanner_top import crs_pkg::*; #(
  parameter int MAX_AREA_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [15:0] record_offset, [47:16] record_flags,
                                      // [63:48] name_length, [79:64] value_length
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);

  item_t   s_item, item;
  logic    item_valid, take;
  result_t result;

  assign s_item.data_word = s_axis_tdata;
  assign s_item.last_word = s_axis_tlast;

  crs_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_item_i     (s_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  crs_core #(
    .MAX_AREA_BYTES (MAX_AREA_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (result)
  );

  // Pack the result transaction
  assign m_axis_tdata = {result.value_length, result.name_length,
                         result.record_flags, result.record_offset};
  assign m_axis_tuser = result.status;
  assign m_axis_tlast = result.area_done;

endmodule

// ----- design/crs_crc32.sv -----
module crs_crc32 import crs_pkg::*; (
  input  logic [31:0] crc_i,
  input  logic [31:0] word_i,
  output logic [31:0] crc_o
);

  logic [31:0] x;

  // Fold one word into the CRC: XOR of the columns picked by set bits
  always_comb begin
    x     = crc_i ^ word_i;
    crc_o = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        crc_o = crc_o ^ CrcCols[i];
      end
    end
  end

endmodule

// ----- design/crs_in_stage.sv -----
module crs_in_stage import crs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  item_t       s_item_i,
  input  logic        take_i,
  output logic        item_valid_o,
  output item_t       item_o
);

  logic  valid_q;
  item_t item_q;

  // Accept when empty or when the held word is consumed this cycle
  assign s_ready_o    = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_valid_i && s_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Hold the payload of each accepted transaction
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

endmodule

// ----- design/crs_core.sv -----
module crs_core import crs_pkg::*; #(
  parameter int MAX_AREA_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        take_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     result_o
);

  localparam int CapInt = (MAX_AREA_BYTES > 131068) ? 131068 : (MAX_AREA_BYTES / 4) * 4;
  localparam logic [16:0] AreaCap = 17'(CapInt);

  logic [16:0] cfg_q;

  phase_e      phase_q, phase_d;
  logic [17:0] pos_q, pos_d;
  logic [15:0] start_q, start_d;
  logic [31:0] exp_q, exp_d;
  logic [31:0] flags_q, flags_d;
  logic [15:0] nlen_q, nlen_d;
  logic [15:0] vlen_q, vlen_d;
  logic [17:0] left_q, left_d;
  logic [31:0] crc_q, crc_d;
  logic        stop_q, stop_d;

  logic        out_valid_q;
  result_t     res_q, res_d;

  logic [16:0] area_masked, area;
  logic        active, reported, has_result, advance;
  status_e     status;
  logic [31:0] w;
  logic [16:0] name_r, val_r;
  logic [17:0] splen, end_pos;
  logic [31:0] crc_seed, crc_next;

  // Effective area length: word aligned and capped
  assign area_masked = {cfg_q[16:2], 2'b00};
  assign area        = (area_masked > AreaCap) ? AreaCap : area_masked;

  assign advance     = item_valid_i && (!out_valid_q || out_ready_i);
  assign take_o      = advance;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  assign w = item_i.data_word;

  // Single CRC unit; the flags word starts from all ones
  assign crc_seed = (phase_q == PH_FLAGS) ? 32'hFFFF_FFFF : crc_q;

  crs_crc32 u_crc (
    .crc_i  (crc_seed),
    .word_i (w),
    .crc_o  (crc_next)
  );

  // Next state and report for one word
  always_comb begin
    phase_d  = phase_q;
    start_d  = start_q;
    exp_d    = exp_q;
    flags_d  = flags_q;
    nlen_d   = nlen_q;
    vlen_d   = vlen_q;
    left_d   = left_q;
    crc_d    = crc_q;
    stop_d   = stop_q;
    reported = 1'b0;
    status   = ST_OK;

    name_r       = {1'b0, w[15:0]} + 17'd3;
    name_r[1:0]  = 2'b00;
    val_r        = {1'b0, w[31:16]} + 17'd3;
    val_r[1:0]   = 2'b00;
    splen        = 18'd16 + {1'b0, name_r} + {1'b0, val_r};
    end_pos      = {2'b00, start_q} + splen;

    active = !stop_q && (pos_q < {1'b0, area});

    if (active) begin
      case (phase_q)
        PH_HUNT: begin
          if (w == ScanMagic) begin
            start_d = pos_q[15:0];
            flags_d = '0;
            nlen_d  = '0;
            vlen_d  = '0;
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          exp_d   = w;
          phase_d = PH_FLAGS;
        end
        PH_FLAGS: begin
          flags_d = w;
          crc_d   = crc_next;
          phase_d = PH_LENS;
        end
        PH_LENS: begin
          nlen_d = w[15:0];
          vlen_d = w[31:16];
          if (end_pos > {1'b0, area}) begin
            status   = ST_BAD_LEN;
            reported = 1'b1;
            stop_d   = 1'b1;
            phase_d  = PH_HUNT;
          end else begin
            crc_d  = crc_next;
            left_d = splen - 18'd16;
            if (left_d == '0) begin
              status   = (~crc_next == exp_q) ? ST_OK : ST_CRC_FAIL;
              reported = 1'b1;
              phase_d  = PH_HUNT;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          crc_d  = crc_next;
          left_d = (left_q >= 18'd4) ? left_q - 18'd4 : '0;
          if (left_d == '0) begin
            status   = (~crc_next == exp_q) ? ST_OK : ST_CRC_FAIL;
            reported = 1'b1;
            phase_d  = PH_HUNT;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end

    // Open record cut short by the end of the stream or the area end
    if (!reported && phase_d != PH_HUNT &&
        (item_i.last_word || ({1'b0, pos_q} + 19'd4 >= {2'b00, area}))) begin
      status   = ST_TRUNC;
      reported = 1'b1;
      stop_d   = 1'b1;
      phase_d  = PH_HUNT;
    end

    pos_d = (pos_q < PosCeiling) ? pos_q + 18'd4 : pos_q;

    has_result = reported || item_i.last_word;
    if (reported) begin
      res_d.status        = status;
      res_d.record_offset = start_d;
      res_d.record_flags  = flags_d;
      res_d.name_length   = nlen_d;
      res_d.value_length  = vlen_d;
    end else begin
      res_d.status        = ST_AREA_END;
      res_d.record_offset = '0;
      res_d.record_flags  = '0;
      res_d.name_length   = '0;
      res_d.value_length  = '0;
    end
    res_d.area_done = item_i.last_word;

    // Start the next area from clean state
    if (item_i.last_word) begin
      phase_d = PH_HUNT;
      pos_d   = '0;
      start_d = '0;
      exp_d   = '0;
      flags_d = '0;
      nlen_d  = '0;
      vlen_d  = '0;
      left_d  = '0;
      crc_d   = 32'hFFFF_FFFF;
      stop_d  = 1'b0;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= AreaReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Scan state, advanced once per consumed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      start_q <= '0;
      exp_q   <= '0;
      flags_q <= '0;
      nlen_q  <= '0;
      vlen_q  <= '0;
      left_q  <= '0;
      crc_q   <= 32'hFFFF_FFFF;
      stop_q  <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      exp_q   <= exp_d;
      flags_q <= flags_d;
      nlen_q  <= nlen_d;
      vlen_q  <= vlen_d;
      left_q  <= left_d;
      crc_q   <= crc_d;
      stop_q  <= stop_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      res_q <= res_d;
    end
  end

  a_stop_in_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> phase_q == PH_HUNT)
    else $error("scan stopped outside hunt phase");

  a_body_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> left_q != '0)
    else $error("body phase with no bytes left");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_i.last_word |=> phase_q == PH_HUNT && pos_q == '0 && !stop_q)
    else $error("state not cleared after area end");

  a_last_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_i.last_word |=> out_valid_q && res_q.area_done)
    else $error("area end gave no report");

endmodule

// ----- dv/crc_checked_record_scanner_top_test.sv -----
module crc_checked_record_scanner_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crs_pkg::*;

  localparam int MaxAreaBytes = 65536;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [16:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] data_word
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // [15:0] record_offset, [47:16] record_flags,
                               // [63:48] name_length, [79:64] value_length
  logic [2:0]  m_axis_tuser;   // [2:0] status
  logic        m_axis_tlast;

  crc_checked_record_scanner_top #(
    .MAX_AREA_BYTES(MaxAreaBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Scanner state as the testbench sees it
  phase_e      scan_phase;
  logic [17:0] scan_pos;
  logic [15:0] rec_start;
  logic [31:0] rec_crc;
  logic [31:0] rec_flags;
  logic [15:0] rec_name_len;
  logic [15:0] rec_value_len;
  logic [31:0] body_left;
  logic [31:0] crc_acc;
  logic        scan_halted;
  logic [16:0] area_cfg;

  result_t     pending_reports[$];
  logic [31:0] area_words[$];
  int          mismatches;
  int          words_sent;
  logic        quiet_run;

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // One bit-serial CRC-32 fold of a whole word, low byte first
  function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int b = 0; b < 32; b++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic logic [31:0] pad4(input logic [15:0] v);
    return ({16'd0, v} + 32'd3) & ~32'd3;
  endfunction

  // Area length after dropping the low bits and clamping to the maximum
  function automatic logic [31:0] area_span();
    logic [31:0] span;
    span = {15'd0, area_cfg} & 32'h0001_FFFC;
    if (span > MaxAreaBytes) span = MaxAreaBytes;
    return span;
  endfunction

  task automatic clear_scan();
    scan_phase    = PH_HUNT;
    scan_pos      = '0;
    rec_start     = '0;
    rec_crc       = '0;
    rec_flags     = '0;
    rec_name_len  = '0;
    rec_value_len = '0;
    body_left     = '0;
    crc_acc       = '1;
    scan_halted   = 1'b0;
  endtask

  // Advance the scan by one accepted word and queue any report it causes
  task automatic predict_word(input logic [31:0] w, input logic lst);
    logic [31:0] span;
    logic [31:0] pos;
    logic [31:0] rec_len;
    logic        hit;
    result_t     rpt;
    span = area_span();
    pos  = {14'd0, scan_pos};
    hit  = 1'b0;
    rpt  = '0;
    rpt.status = ST_AREA_END;
    if (!scan_halted && pos < span) begin
      case (scan_phase)
        PH_HUNT: begin
          if (w == ScanMagic) begin
            rec_start     = pos[15:0];
            rec_flags     = '0;
            rec_name_len  = '0;
            rec_value_len = '0;
            scan_phase    = PH_CRC;
          end
        end
        PH_CRC: begin
          rec_crc    = w;
          scan_phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          rec_flags  = w;
          crc_acc    = crc32_fold('1, w);
          scan_phase = PH_LENS;
        end
        PH_LENS: begin
          rec_name_len  = w[15:0];
          rec_value_len = w[31:16];
          rec_len = 32'd16 + pad4(w[15:0]) + pad4(w[31:16]);
          if ({16'd0, rec_start} + rec_len > span) begin
            rpt.status  = ST_BAD_LEN;
            hit         = 1'b1;
            scan_halted = 1'b1;
            scan_phase  = PH_HUNT;
          end else begin
            crc_acc   = crc32_fold(crc_acc, w);
            body_left = rec_len - 32'd16;
            if (body_left == 0) begin
              hit        = 1'b1;
              scan_phase = PH_HUNT;
              if (~crc_acc == rec_crc) rpt.status = ST_OK;
              else rpt.status = ST_CRC_FAIL;
            end else begin
              scan_phase = PH_BODY;
            end
          end
        end
        default: begin
          crc_acc   = crc32_fold(crc_acc, w);
          body_left = (body_left >= 4) ? body_left - 32'd4 : 32'd0;
          if (body_left == 0) begin
            hit        = 1'b1;
            scan_phase = PH_HUNT;
            if (~crc_acc == rec_crc) rpt.status = ST_OK;
            else rpt.status = ST_CRC_FAIL;
          end
        end
      endcase
    end
    // An open record cut off by the end of the stream or the area bound
    if (!hit && scan_phase != PH_HUNT && (lst || pos + 32'd4 >= span)) begin
      rpt.status  = ST_TRUNC;
      hit         = 1'b1;
      scan_halted = 1'b1;
      scan_phase  = PH_HUNT;
    end
    if (scan_pos < PosCeiling) scan_pos = scan_pos + 18'd4;
    if (hit || lst) begin
      if (hit) begin
        rpt.record_offset = rec_start;
        rpt.record_flags  = rec_flags;
        rpt.name_length   = rec_name_len;
        rpt.value_length  = rec_value_len;
      end
      rpt.area_done = lst;
      pending_reports.push_back(rpt);
    end
    if (lst) clear_scan();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_report();
    result_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch("report with none pending, status", {29'd0, m_axis_tuser}, 32'd0);
      return;
    end
    want = pending_reports.pop_front();
    if (m_axis_tuser !== want.status)
      report_mismatch("status", {29'd0, m_axis_tuser}, {29'd0, want.status});
    if (m_axis_tdata[15:0] !== want.record_offset)
      report_mismatch("record_offset", {16'd0, m_axis_tdata[15:0]}, {16'd0, want.record_offset});
    if (m_axis_tdata[47:16] !== want.record_flags)
      report_mismatch("record_flags", m_axis_tdata[47:16], want.record_flags);
    if (m_axis_tdata[63:48] !== want.name_length)
      report_mismatch("name_length", {16'd0, m_axis_tdata[63:48]}, {16'd0, want.name_length});
    if (m_axis_tdata[79:64] !== want.value_length)
      report_mismatch("value_length", {16'd0, m_axis_tdata[79:64]}, {16'd0, want.value_length});
    if (m_axis_tlast !== want.area_done)
      report_mismatch("area_done", {31'd0, m_axis_tlast}, {31'd0, want.area_done});
  endtask

  // Predict on every input transaction, check every output transaction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) predict_word(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_report();
  end

  // Result side: stall a random number of cycles before each transaction
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = quiet_run ? 0 : $urandom_range(0, 12);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_word(input logic [31:0] w, input logic lst);
    int gap;
    gap = quiet_run ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold input until every report is back and the pipeline has emptied
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_area(input logic [16:0] bytes);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bytes;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    area_cfg = bytes;
  endtask

  // Append one record with a stored CRC that matches or is corrupted
  task automatic add_record(input logic good, input logic [31:0] flags,
                            input logic [15:0] name_len, input logic [15:0] value_len);
    logic [31:0] crc;
    logic [31:0] w;
    int          crc_slot;
    int          n_body;
    area_words.push_back(ScanMagic);
    crc_slot = area_words.size();
    area_words.push_back(32'd0);
    area_words.push_back(flags);
    area_words.push_back({value_len, name_len});
    crc = crc32_fold(crc32_fold('1, flags), {value_len, name_len});
    n_body = int'((pad4(name_len) + pad4(value_len)) / 4);
    if (n_body > 64) n_body = 0;
    for (int i = 0; i < n_body; i++) begin
      w = $urandom;
      area_words.push_back(w);
      crc = crc32_fold(crc, w);
    end
    area_words[crc_slot] = good ? ~crc : ~crc ^ (32'd1 << $urandom_range(0, 31));
  endtask

  task automatic send_area();
    for (int i = 0; i < area_words.size(); i++) begin
      send_word(area_words[i], i == area_words.size() - 1);
      words_sent++;
    end
  endtask

  // Mostly well-formed records, with noise and broken headers mixed in
  task automatic fill_area(input int n_words);
    logic [15:0] nl;
    logic [15:0] vl;
    int          k;
    area_words.delete();
    while (area_words.size() < n_words) begin
      k = $urandom_range(0, 9);
      if (k <= 5) begin
        if ($urandom_range(0, 15) == 0) begin
          nl = 16'($urandom);
          vl = 16'($urandom);
        end else begin
          nl = 16'($urandom_range(0, 20));
          vl = 16'($urandom_range(0, 20));
        end
        add_record($urandom_range(0, 3) != 0, $urandom, nl, vl);
      end else if (k <= 7) begin
        repeat ($urandom_range(1, 3))
          area_words.push_back(($urandom_range(0, 3) == 0) ? ScanMagic : $urandom);
      end else begin
        area_words.push_back(ScanMagic);
        repeat ($urandom_range(0, 3)) area_words.push_back($urandom);
      end
    end
    while (area_words.size() > n_words) void'(area_words.pop_back());
  endtask

  // Ok, crc fail, bad length, then words after the stop and the area end
  task automatic test_directed_records();
    area_words.delete();
    add_record(1'b1, 32'hFFFF_FFFF, 16'd0, 16'd0);
    add_record(1'b0, 32'h0000_0000, 16'd1, 16'd3);
    add_record(1'b1, 32'h0000_0001, 16'hFFFF, 16'hFFFF);
    area_words.push_back(ScanMagic);
    area_words.push_back(32'h0000_0000);
    send_area();
  endtask

  // Truncation before the header, at the bound and at the end of the stream
  task automatic test_area_bounds();
    write_area(17'd4);
    area_words = '{ScanMagic};
    send_area();
    area_words = '{32'h0000_0000};
    send_area();
    write_area(17'd8);
    area_words = '{ScanMagic, 32'hFFFF_FFFF, ScanMagic};
    send_area();
    write_area(17'd24);
    area_words.delete();
    add_record(1'b1, 32'h8000_0000, 16'd4, 16'd4);
    area_words.push_back(32'h0000_0000);
    send_area();
    write_area(17'h1_0000);
    area_words = '{ScanMagic, 32'h1234_5678, 32'hA5A5_5A5A};
    send_area();
  endtask

  task automatic test_random_areas();
    int          n;
    int          span_words;
    logic [16:0] bytes;
    while (words_sent < 590) begin
      quiet_run = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0:       bytes = 17'd4;
          1:       bytes = 17'h1_0000;
          2:       bytes = AreaReset;
          default: bytes = 17'(4 * $urandom_range(4, 64));
        endcase
        write_area(bytes);
      end
      span_words = int'(area_span() / 4);
      case ($urandom_range(0, 2))
        0:       n = span_words + $urandom_range(0, 3);
        1:       n = $urandom_range(1, span_words);
        default: n = $urandom_range(8, 60);
      endcase
      if (n > 90) n = $urandom_range(20, 90);
      fill_area(n);
      send_area();
    end
    quiet_run = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    quiet_run     = 1'b0;
    mismatches    = 0;
    words_sent    = 0;
    area_cfg      = AreaReset;
    clear_scan();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_records();
    test_area_bounds();
    test_random_areas();
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("crc_checked_record_scanner_top test passed");
    end else begin
      $display("crc_checked_record_scanner_top test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("crc_checked_record_scanner_top test failed");
    $finish;
  end

endmodule

// ----- crc_checked_record_scanner_top.f -----
design/crs_pkg.sv
design/crs_crc32.sv
design/crs_in_stage.sv
design/crs_core.sv
design/crc_checked_record_scanner_top.sv
dv/crc_checked_record_scanner_top_test.sv
